// ===== design/rfm_pkg.sv =====
// ----------------------------------------------------------------------------
// rfm_pkg: shared types and constants for the reciprocal frequency meter
// item layouts, register map, op codes, control states and default widths
// ----------------------------------------------------------------------------
package rfm_pkg;

    // default widths of the counting state
    localparam int ACC_WIDTH_DEF   = 48;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int TICK_RATE_W    = 24;
    localparam int TIMER_PERIOD_W = 16;
    localparam int CAPTURE_W      = 16;
    localparam int FREQ_W         = 32;
    localparam int FRAC_BITS      = 8;

    // register port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_TICK_RATE    = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMER_PERIOD = 1'd1;

    localparam logic [TICK_RATE_W-1:0]    TICK_RATE_RESET    = 24'd250000;
    localparam logic [TIMER_PERIOD_W-1:0] TIMER_PERIOD_RESET = 16'd50000;

    // op codes of an input item
    localparam logic [1:0] OP_OVERFLOW = 2'd0;
    localparam logic [1:0] OP_CAPTURE  = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic [CAPTURE_W-1:0] capture_value;
    } in_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic              no_edges;
        logic              zero_period;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_RESULT
    } state_t;

endpackage

// ===== design/reciprocal_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// reciprocal_frequency_meter: frequency from input-capture events
// counts timer overflows and capture edges, and answers a query with
// tick_rate * edges * 256 / ticks as unsigned q24.8, saturating
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item per event; op selects overflow, capture or query
//   m_ channel: one result item per query, none for other ops
//   apb port: tick_rate at 0x0, timer_period at 0x4, write only while idle
// timing
//   overflow: taken while idle, the next item can follow at once
//   capture: a shift-add multiplier forms
//     timer_period * pending overflows one bit a cycle, then one add
//   query: the same multiplier forms the numerator, then a restoring divider
//     takes one quotient bit a cycle; no edges or zero ticks skip the arithmetic
//   one item is in work at a time; s_ready is high only when idle
// reset and stalls
//   reset clears all counters, loads default register values, drops m_valid
//   a result waits in the output register while m_ready is low; items that
//   give no result are still taken, a further query is worked out and then
//   waits for the slot, holding off the input meanwhile
// ----------------------------------------------------------------------------
module reciprocal_frequency_meter #(
    parameter int ACC_WIDTH   = rfm_pkg::ACC_WIDTH_DEF,
    parameter int COUNT_WIDTH = rfm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // event items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rfm_pkg::in_item_t           s_item,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output rfm_pkg::out_item_t          m_item,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfm_pkg::ADDR_W-1:0]  paddr,
    input  logic [rfm_pkg::DATA_W-1:0]  pwdata,
    output logic [rfm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // multiplicand is the wider of the two registers
    localparam int MCAND_W = rfm_pkg::TICK_RATE_W;
    localparam int PROD_W  = MCAND_W + COUNT_WIDTH;
    // numerator bits fed to the divider: product then fraction zeros
    localparam int NUM_W   = PROD_W + rfm_pkg::FRAC_BITS;
    localparam int SUM_W   = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 2;
    localparam int STEP_W  = $clog2(NUM_W);
    localparam int FW      = rfm_pkg::FREQ_W;

    localparam logic [STEP_W-1:0]      MUL_LAST = STEP_W'(COUNT_WIDTH - 1);
    localparam logic [STEP_W-1:0]      DIV_LAST = STEP_W'(NUM_W - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [ACC_WIDTH-1:0]   ACC_MAX  = '1;

    // control state
    rfm_pkg::state_t state_reg, state_next;
    logic [rfm_pkg::TICK_RATE_W-1:0]    tick_rate_reg, tick_rate_next;
    logic [rfm_pkg::TIMER_PERIOD_W-1:0] timer_period_reg, timer_period_next;
    logic [COUNT_WIDTH-1:0]             pend_reg, pend_next;
    logic [ACC_WIDTH-1:0]               acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0]             edge_reg, edge_next;
    logic [STEP_W-1:0]                  step_reg, step_next;
    logic                               m_valid_reg, m_valid_next;

    // datapath
    logic [PROD_W-1:0]                  prod_reg, prod_next;
    logic [ACC_WIDTH-1:0]               rem_reg, rem_next;
    logic [FW-1:0]                      quot_reg, quot_next;
    logic                               sat_reg, sat_next;
    logic [rfm_pkg::CAPTURE_W-1:0]      cap_reg, cap_next;
    logic                               is_query_reg, is_query_next;
    logic                               noe_reg, noe_next;
    logic                               zp_reg, zp_next;
    rfm_pkg::out_item_t                 m_item_reg, m_item_next;

    // strobes
    logic s_fire;
    logic out_free;
    logic result_load;
    logic cfg_wr;
    logic [rfm_pkg::REG_IDX_W-1:0] reg_idx;

    // working values
    logic [MCAND_W-1:0]   mcand;
    logic [MCAND_W:0]     mul_sum;
    logic [SUM_W-1:0]     acc_sum;
    logic [ACC_WIDTH:0]   rem_shift;
    logic [ACC_WIDTH:0]   rem_diff;
    logic                 q_bit;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[rfm_pkg::ADDR_W-1:2];

    always_comb begin
        unique case (reg_idx)
            rfm_pkg::REG_TICK_RATE:    prdata = rfm_pkg::DATA_W'(tick_rate_reg);
            rfm_pkg::REG_TIMER_PERIOD: prdata = rfm_pkg::DATA_W'(timer_period_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rfm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.op == rfm_pkg::OP_CAPTURE) begin
                        state_next = rfm_pkg::ST_MUL;
                    end else if (s_item.op == rfm_pkg::OP_QUERY) begin
                        // degenerate queries skip the arithmetic
                        if (edge_reg == '0 || acc_reg == '0) begin
                            state_next = rfm_pkg::ST_RESULT;
                        end else begin
                            state_next = rfm_pkg::ST_MUL;
                        end
                    end
                end
            end
            rfm_pkg::ST_MUL: begin
                if (step_reg == '0) begin
                    state_next = is_query_reg ? rfm_pkg::ST_DIV : rfm_pkg::ST_ACC;
                end
            end
            rfm_pkg::ST_ACC: begin
                state_next = rfm_pkg::ST_IDLE;
            end
            rfm_pkg::ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = rfm_pkg::ST_RESULT;
                end
            end
            rfm_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = rfm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rfm_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready     = (state_reg == rfm_pkg::ST_IDLE);
        out_free    = !m_valid_reg || m_ready;
        result_load = (state_reg == rfm_pkg::ST_RESULT) && out_free;
    end

    assign s_fire = s_valid && s_ready;

    // ------------------------------------------------------------------
    // arithmetic slices
    // ------------------------------------------------------------------
    // shift-add multiplier: multiplier bits sit in the low end of prod_reg
    // and leave to the right as partial sums enter at the top
    assign mcand   = is_query_reg ? tick_rate_reg : MCAND_W'(timer_period_reg);
    assign mul_sum = {1'b0, prod_reg[PROD_W-1:COUNT_WIDTH]}
                   + (prod_reg[0] ? {1'b0, mcand} : '0);

    // capture add, saturating at the accumulator maximum
    assign acc_sum = SUM_W'(acc_reg) + SUM_W'(cap_reg) + SUM_W'(prod_reg);

    // restoring division, numerator bits taken msb first from prod_reg
    assign rem_shift = {rem_reg, prod_reg[PROD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, acc_reg};
    assign q_bit     = !rem_diff[ACC_WIDTH];

    // ------------------------------------------------------------------
    // next values
    // ------------------------------------------------------------------
    always_comb begin
        tick_rate_next    = tick_rate_reg;
        timer_period_next = timer_period_reg;
        pend_next         = pend_reg;
        acc_next          = acc_reg;
        edge_next         = edge_reg;
        step_next         = step_reg;
        m_valid_next      = m_valid_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        sat_next          = sat_reg;
        cap_next          = cap_reg;
        is_query_next     = is_query_reg;
        noe_next          = noe_reg;
        zp_next           = zp_reg;
        m_item_next       = m_item_reg;

        if (cfg_wr) begin
            unique case (reg_idx)
                rfm_pkg::REG_TICK_RATE:
                    tick_rate_next = pwdata[rfm_pkg::TICK_RATE_W-1:0];
                rfm_pkg::REG_TIMER_PERIOD:
                    timer_period_next = pwdata[rfm_pkg::TIMER_PERIOD_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            rfm_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_item.op)
                        rfm_pkg::OP_OVERFLOW: begin
                            if (pend_reg != CNT_MAX) begin
                                pend_next = pend_reg + COUNT_WIDTH'(1);
                            end
                        end
                        rfm_pkg::OP_CAPTURE: begin
                            cap_next      = s_item.capture_value;
                            prod_next     = PROD_W'(pend_reg);
                            is_query_next = 1'b0;
                            step_next     = MUL_LAST;
                        end
                        rfm_pkg::OP_QUERY: begin
                            prod_next     = PROD_W'(edge_reg);
                            is_query_next = 1'b1;
                            step_next     = MUL_LAST;
                            quot_next     = '0;
                            sat_next      = 1'b0;
                            rem_next      = '0;
                            noe_next      = (edge_reg == '0);
                            zp_next       = (edge_reg != '0) && (acc_reg == '0);
                        end
                        default: ;
                    endcase
                end
            end
            rfm_pkg::ST_MUL: begin
                prod_next = {mul_sum, prod_reg[COUNT_WIDTH-1:1]};
                if (step_reg == '0) begin
                    step_next = DIV_LAST;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            rfm_pkg::ST_ACC: begin
                if (acc_sum[SUM_W-1:ACC_WIDTH] != '0) begin
                    acc_next = ACC_MAX;
                end else begin
                    acc_next = acc_sum[ACC_WIDTH-1:0];
                end
                if (edge_reg != CNT_MAX) begin
                    edge_next = edge_reg + COUNT_WIDTH'(1);
                end
                pend_next = '0;
            end
            rfm_pkg::ST_DIV: begin
                rem_next  = q_bit ? rem_diff[ACC_WIDTH-1:0] : rem_shift[ACC_WIDTH-1:0];
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                quot_next = {quot_reg[FW-2:0], q_bit};
                // a set bit leaving the top means the quotient needs more than 32 bits
                sat_next  = sat_reg | quot_reg[FW-1];
                if (step_reg != '0) begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            rfm_pkg::ST_RESULT: ;
            default: ;
        endcase

        // output register
        if (result_load) begin
            m_item_next.frequency   = sat_reg ? '1 : quot_reg;
            m_item_next.no_edges    = noe_reg;
            m_item_next.zero_period = zp_reg;
            m_valid_next            = 1'b1;
            acc_next                = '0;
            edge_next               = '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= rfm_pkg::ST_IDLE;
            tick_rate_reg    <= rfm_pkg::TICK_RATE_RESET;
            timer_period_reg <= rfm_pkg::TIMER_PERIOD_RESET;
            pend_reg         <= '0;
            acc_reg          <= '0;
            edge_reg         <= '0;
            step_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            tick_rate_reg    <= tick_rate_next;
            timer_period_reg <= timer_period_next;
            pend_reg         <= pend_next;
            acc_reg          <= acc_next;
            edge_reg         <= edge_next;
            step_reg         <= step_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        sat_reg      <= sat_next;
        cap_reg      <= cap_next;
        is_query_reg <= is_query_next;
        noe_reg      <= noe_next;
        zp_reg       <= zp_next;
        m_item_reg   <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the two degenerate flags exclude each other
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.no_edges && m_item.zero_period))
        else $error("no_edges and zero_period both set");

    // a flagged result carries zero frequency
    a_flag_zero_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.no_edges || m_item.zero_period)) |-> (m_item.frequency == '0))
        else $error("flagged result with nonzero frequency");

    // delivering a query result clears the measurement window
    a_query_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        result_load |=> (acc_reg == '0 && edge_reg == '0 && m_valid_reg))
        else $error("query did not clear accumulator and edge count");

    // a capture commit empties the pending overflow count
    a_capture_clears_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rfm_pkg::ST_ACC) |=> (pend_reg == '0))
        else $error("pending overflows not cleared by capture");

endmodule
